>>> hdl/euclid_gcd_lcm_core_macros.svh
// Assertion macros used by the GCD/LCM core.
`ifndef EUCLID_GCD_LCM_CORE_MACROS_SVH
`define EUCLID_GCD_LCM_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset only.
`define ECL_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ecl assertion failed");

// Next-cycle implication, checked out of reset only.
`define ECL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ecl assertion failed");

`endif

>>> hdl/ecl_pkg.sv
// Types shared by the GCD/LCM core and its divider.
package ecl_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_REM_GO,
    S_REM_WAIT,
    S_QUO_GO,
    S_QUO_WAIT,
    S_MUL
  } ecl_state_e;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } ecl_div_stat_t;

endpackage

>>> hdl/ecl_div.sv
// Iterative restoring divider: one quotient bit per cycle.
module ecl_div #(
  parameter int W = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [W-1:0]          dividend_i,
  input  logic [W-1:0]          divisor_i,
  output logic [W-1:0]          quotient_o,
  output logic [W-1:0]          remainder_o,
  output ecl_pkg::ecl_div_stat_t stat_o
);
  import ecl_pkg::*;

  localparam int CntW = $clog2(W + 1);

  logic [W-1:0]    rem_q, rem_d;
  logic [W-1:0]    quo_q, quo_d;
  logic [W-1:0]    dvs_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [W:0]      shifted;
  logic [W:0]      diff;

  // Start load or one shift-subtract step
  always_comb begin
    shifted = {rem_q, quo_q[W-1]};
    diff    = shifted - {1'b0, dvs_q};
    rem_d   = rem_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      cnt_d  = CntW'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (shifted >= {1'b0, dvs_q}) begin
        rem_d = diff[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = shifted[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;
  assign stat_o      = '{busy: busy_q, done: done_q};

endmodule

>>> hdl/euclid_gcd_lcm_core.sv
// Euclidean GCD/LCM core: sequencer, operand registers, multiplier and output register.
//
// Input channel: in_valid_i / in_stall_o with operand_a_i, operand_b_i. Only the
// low OPERAND_WIDTH bits of each operand are used. An item is taken when valid is
// high and stall is low; stall stays high while an item is being worked on.
// Output channel: out_valid_o / out_stall_i with gcd_value_o, lcm_value_o and
// zero_error_o, one result per item, held in a register until taken.
// Each Euclid remainder step runs on the shared bit-serial divider; the step
// count depends on the data (at most about 1.44 * OPERAND_WIDTH steps). The
// final a / gcd quotient also runs on the divider, followed by the multiply.
// A zero operand skips the divider and goes straight to the multiply step,
// where the error result is loaded into the output register.
// Items are handled one at a time; a new item is accepted while the previous
// result still waits in the output register.
// When the receiver stalls, the result holds and the block waits at the
// multiply step before overwriting it.
// Reset clears the sequencer and the output valid; no result is pending after it.
`include "euclid_gcd_lcm_core_macros.svh"
module euclid_gcd_lcm_core #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] gcd_value_o,
  output logic [63:0] lcm_value_o,
  output logic        zero_error_o
);
  import ecl_pkg::*;

  localparam int W = OPERAND_WIDTH;

  ecl_state_e    state_q, state_d;
  ecl_div_stat_t div_stat;

  logic [W-1:0]   a_in, b_in;
  logic           in_zero, in_acc, out_free;
  logic [W-1:0]   a_q, b_q, big_q, small_q, quo_q;
  logic           err_q;
  logic [W-1:0]   div_dividend, div_divisor, div_quo, div_rem;
  logic           div_start, load_in, take_rem, take_quo, load_out;
  logic [2*W-1:0] prod;
  logic           out_valid_q;
  logic [31:0]    gcd_q;
  logic [63:0]    lcm_q;
  logic           zerr_q;

  // Operand masking and handshake
  assign a_in     = operand_a_i[W-1:0];
  assign b_in     = operand_b_i[W-1:0];
  assign in_zero  = (a_in == '0) || (b_in == '0);
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:     if (in_acc) state_d = in_zero ? S_MUL : S_REM_GO;
      S_REM_GO:   state_d = S_REM_WAIT;
      S_REM_WAIT: begin
        if (div_stat.done) state_d = (div_rem == '0) ? S_QUO_GO : S_REM_GO;
      end
      S_QUO_GO:   state_d = S_QUO_WAIT;
      S_QUO_WAIT: if (div_stat.done) state_d = S_MUL;
      S_MUL:      if (out_free) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    div_start    = 1'b0;
    load_in      = 1'b0;
    take_rem     = 1'b0;
    take_quo     = 1'b0;
    load_out     = 1'b0;
    div_dividend = big_q;
    div_divisor  = small_q;
    unique case (state_q)
      S_IDLE:     load_in = in_acc;
      S_REM_GO:   div_start = 1'b1;
      S_REM_WAIT: take_rem = div_stat.done;
      S_QUO_GO: begin
        div_start    = 1'b1;
        div_dividend = a_q;
        div_divisor  = big_q;
      end
      S_QUO_WAIT: take_quo = div_stat.done;
      S_MUL:      load_out = out_free;
      default:    ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Shared divider: remainders for Euclid, then a / gcd
  ecl_div #(
    .W(W)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .quotient_o  (div_quo),
    .remainder_o (div_rem),
    .stat_o      (div_stat)
  );

  // Operand and Euclid registers
  always_ff @(posedge clk_i) begin
    if (load_in) begin
      a_q     <= a_in;
      b_q     <= b_in;
      big_q   <= (a_in >= b_in) ? a_in : b_in;
      small_q <= (a_in >= b_in) ? b_in : a_in;
      err_q   <= in_zero;
    end else if (take_rem) begin
      big_q   <= small_q;
      small_q <= div_rem;
    end
    if (take_quo) begin
      quo_q <= div_quo;
    end
  end

  // (a / gcd) * b at double width
  assign prod = (2*W)'(quo_q) * (2*W)'(b_q);

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      gcd_q  <= err_q ? 32'd0 : 32'(big_q);
      lcm_q  <= err_q ? 64'd0 : 64'(prod);
      zerr_q <= err_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign gcd_value_o  = gcd_q;
  assign lcm_value_o  = lcm_q;
  assign zero_error_o = zerr_q;

  // Checks
  `ECL_ASSERT_NEXT(a_accept_leaves_idle, clk_i, rst_ni, in_acc, state_q != S_IDLE)
  `ECL_ASSERT_SAME(a_start_when_free, clk_i, rst_ni, div_start, !div_stat.busy)
  `ECL_ASSERT_SAME(a_done_when_waiting, clk_i, rst_ni, div_stat.done,
                   (state_q == S_REM_WAIT) || (state_q == S_QUO_WAIT))
  `ECL_ASSERT_SAME(a_gcd_nonzero, clk_i, rst_ni, out_valid_o && !zero_error_o,
                   gcd_value_o != 32'd0)

endmodule
